@@ src/atrp_pkg.sv @@
`default_nettype none

package atrp_pkg;

    // Raw sample and angle widths
    localparam int unsigned IN_W      = 16;
    localparam int unsigned ROLL_W    = 16;
    localparam int unsigned PITCH_W   = 15;

    // Operands are raw counts scaled by 2^SCALE_SH
    localparam int unsigned SCALE_SH  = 8;

    // Magnitude path: y*y + z*z, shifted up by 2*SCALE_SH, then integer square root
    localparam int unsigned PROD_W    = 2 * IN_W - 1;
    localparam int unsigned SUM_W     = 2 * IN_W;
    localparam int unsigned RAD_W     = SUM_W + 2 * SCALE_SH;
    localparam int unsigned SQRT_BITS = RAD_W / 2;
    localparam int unsigned REM_W     = SQRT_BITS + 2;

    // CORDIC vector and angle accumulator (1/65536 degree)
    localparam int unsigned CW        = 28;
    localparam int unsigned ACC_W     = 26;
    localparam int unsigned RND_SH    = 9;
    localparam int unsigned RND_W     = ACC_W - RND_SH;

    localparam logic signed [ACC_W-1:0] DEG180   = 26'sd11796480;
    localparam logic signed [ACC_W-1:0] RND_HALF = 26'sd256;
    localparam logic signed [RND_W-1:0] ROLL_LIM  = 17'sd23040;
    localparam logic signed [RND_W-1:0] PITCH_LIM = 17'sd11520;

    // Magnitude pipeline payload
    typedef struct packed {
        logic signed [IN_W-1:0]  x;
        logic signed [IN_W-1:0]  y;
        logic signed [IN_W-1:0]  z;
        logic [RAD_W-1:0]        rad;
        logic [REM_W-1:0]        rem;
        logic [SQRT_BITS-1:0]    root;
    } t_sqrt_stage;

    // One CORDIC vector with its angle
    typedef struct packed {
        logic signed [CW-1:0]    xv;
        logic signed [CW-1:0]    yv;
        logic signed [ACC_W-1:0] acc;
        logic                    zero;
    } t_vec;

    typedef struct packed {
        t_vec roll;
        t_vec pitch;
    } t_cordic_stage;

    // atan(2^-i) in degrees * 65536, rounded to nearest
    function automatic logic signed [ACC_W-1:0] atan_entry(input int unsigned idx);
        logic signed [ACC_W-1:0] val;
        case (idx)
            0:       val = 26'sd2949120;
            1:       val = 26'sd1740967;
            2:       val = 26'sd919879;
            3:       val = 26'sd466945;
            4:       val = 26'sd234379;
            5:       val = 26'sd117304;
            6:       val = 26'sd58666;
            7:       val = 26'sd29335;
            8:       val = 26'sd14668;
            9:       val = 26'sd7334;
            10:      val = 26'sd3667;
            11:      val = 26'sd1833;
            12:      val = 26'sd917;
            13:      val = 26'sd458;
            14:      val = 26'sd229;
            15:      val = 26'sd115;
            16:      val = 26'sd57;
            17:      val = 26'sd29;
            18:      val = 26'sd14;
            19:      val = 26'sd7;
            20:      val = 26'sd4;
            21:      val = 26'sd2;
            22:      val = 26'sd1;
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

`default_nettype wire

@@ src/atrp_if.sv @@
`default_nettype none

// Sample channel: one raw accelerometer reading per transaction
interface atrp_in_if;
    logic                valid;
    logic                ready;
    logic signed [15:0]  x_accel;
    logic signed [15:0]  y_accel;
    logic signed [15:0]  z_accel;

    modport source (output valid, output x_accel, output y_accel, output z_accel,
                    input ready);
    modport sink   (input valid, input x_accel, input y_accel, input z_accel,
                    output ready);
endinterface

// Angle channel: roll and pitch per transaction
interface atrp_out_if;
    logic                valid;
    logic                ready;
    logic signed [15:0]  roll_angle;
    logic signed [14:0]  pitch_angle;

    modport source (output valid, output roll_angle, output pitch_angle, input ready);
    modport sink   (input valid, input roll_angle, input pitch_angle, output ready);
endinterface

`default_nettype wire

@@ src/accel_tilt_roll_pitch_unit.sv @@
`default_nettype none

// Tilt angles from one raw three-axis accelerometer sample.
// i_sample (valid/ready) carries x_accel, y_accel, z_accel; o_angle (valid/ready)
// returns roll_angle = atan2(y, z) and pitch_angle = atan2(-x, sqrt(y^2 + z^2)),
// both in 1/128 degree, rounded to nearest and saturated to +-180 / +-90 degrees.
// Exactly one angle transaction per sample transaction, in order.
// Pipeline: input register, squaring, sum, a 24-step digit-by-digit square root,
// CORDIC setup, ANGLE_STEPS vectoring CORDIC stages (roll and pitch side by side),
// then rounding into the output register.
// Throughput: one sample per cycle while the skid entry is empty, set by the fully
// unrolled square-root and CORDIC stages.
// The output register has a one-entry skid buffer behind it. i_sample.ready
// drops only while the skid entry is full, so the pipeline keeps taking samples
// while a result waits; a stalled receiver loses or repeats nothing.
// Reset (synchronous, active low) empties every pipeline stage and the output.
module accel_tilt_roll_pitch_unit #(
    parameter int unsigned ANGLE_STEPS = 16
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    atrp_in_if.sink    i_sample,
    atrp_out_if.source o_angle
);
    import atrp_pkg::*;

    localparam int unsigned NSTG = SQRT_BITS + ANGLE_STEPS + 4;

    // Stage helpers ------------------------------------------------------

    function automatic t_sqrt_stage sqrt_step(input t_sqrt_stage s);
        t_sqrt_stage           o;
        logic [REM_W+1:0]      rem2;
        logic [REM_W+1:0]      trial;
        o     = s;
        rem2  = {s.rem, s.rad[RAD_W-1 -: 2]};
        trial = {2'b00, s.root, 2'b01};
        if (rem2 >= trial) begin
            o.rem  = REM_W'(rem2 - trial);
            o.root = {s.root[SQRT_BITS-2:0], 1'b1};
        end else begin
            o.rem  = rem2[REM_W-1:0];
            o.root = {s.root[SQRT_BITS-2:0], 1'b0};
        end
        o.rad = {s.rad[RAD_W-3:0], 2'b00};
        return o;
    endfunction

    // Fold a left-half-plane vector into the right half, preset acc to +-180
    function automatic t_vec vec_setup(input logic signed [CW-1:0] xv,
                                       input logic signed [CW-1:0] yv);
        t_vec v;
        v.zero = (xv == '0) && (yv == '0);
        if (xv < 0) begin
            v.acc = (yv >= 0) ? DEG180 : -DEG180;
            v.xv  = -xv;
            v.yv  = -yv;
        end else begin
            v.acc = '0;
            v.xv  = xv;
            v.yv  = yv;
        end
        return v;
    endfunction

    function automatic t_vec vec_rotate(input t_vec v, input int unsigned sh,
                                        input logic signed [ACC_W-1:0] ang);
        t_vec                 o;
        logic signed [CW-1:0] dx;
        logic signed [CW-1:0] dy;
        o  = v;
        dx = v.yv >>> sh;
        dy = v.xv >>> sh;
        if (v.yv > 0) begin
            o.xv  = v.xv + dx;
            o.yv  = v.yv - dy;
            o.acc = v.acc + ang;
        end else begin
            o.xv  = v.xv - dx;
            o.yv  = v.yv + dy;
            o.acc = v.acc - ang;
        end
        return o;
    endfunction

    function automatic logic signed [RND_W-1:0] round_sat(input t_vec v,
                                                          input logic signed [RND_W-1:0] lim);
        logic signed [ACC_W-1:0] s;
        logic signed [RND_W-1:0] r;
        s = v.acc + RND_HALF;
        r = $signed(s[ACC_W-1:RND_SH]);
        if (v.zero) begin
            r = '0;
        end else if (r > lim) begin
            r = lim;
        end else if (r < -lim) begin
            r = -lim;
        end
        return r;
    endfunction

    // Pipeline control ---------------------------------------------------

    logic              w_en;
    logic [NSTG-1:0]   r_valid;
    logic              r_out_valid;
    logic              r_skid_valid;

    // Whole pipeline advances unless the skid entry is occupied
    assign w_en           = !r_skid_valid;
    assign i_sample.ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (w_en) begin
            r_valid <= {r_valid[NSTG-2:0], i_sample.valid};
        end
    end

    // Input and squaring stages ------------------------------------------

    logic signed [IN_W-1:0]   r_in_x, r_in_y, r_in_z;
    logic signed [IN_W-1:0]   r_m_x, r_m_y, r_m_z;
    logic [PROD_W-1:0]        r_m_py, r_m_pz;
    logic signed [2*IN_W-1:0] w_py, w_pz;

    assign w_py = r_in_y * r_in_y;
    assign w_pz = r_in_z * r_in_z;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_in_x <= i_sample.x_accel;
            r_in_y <= i_sample.y_accel;
            r_in_z <= i_sample.z_accel;
            r_m_x  <= r_in_x;
            r_m_y  <= r_in_y;
            r_m_z  <= r_in_z;
            r_m_py <= w_py[PROD_W-1:0];
            r_m_pz <= w_pz[PROD_W-1:0];
        end
    end

    // Sum and square root stages (entry 0 holds the radicand) -------------

    t_sqrt_stage r_sq [SQRT_BITS+1];
    t_sqrt_stage w_sq0;

    always_comb begin
        w_sq0.x    = r_m_x;
        w_sq0.y    = r_m_y;
        w_sq0.z    = r_m_z;
        w_sq0.rad  = {SUM_W'(r_m_py) + SUM_W'(r_m_pz), (2*SCALE_SH)'(0)};
        w_sq0.rem  = '0;
        w_sq0.root = '0;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sq[0] <= w_sq0;
        end
    end

    for (genvar j = 0; j < SQRT_BITS; j++) begin : g_sqrt
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_sq[j+1] <= sqrt_step(r_sq[j]);
            end
        end
    end

    // CORDIC setup and micro-rotations ----------------------------------

    t_cordic_stage        r_cr [ANGLE_STEPS+1];
    t_cordic_stage        w_pre;
    logic signed [CW-1:0] w_roll_x, w_roll_y, w_pitch_x, w_pitch_y;

    always_comb begin
        w_roll_x  = CW'(r_sq[SQRT_BITS].z) <<< SCALE_SH;
        w_roll_y  = CW'(r_sq[SQRT_BITS].y) <<< SCALE_SH;
        w_pitch_x = $signed({{(CW-SQRT_BITS){1'b0}}, r_sq[SQRT_BITS].root});
        w_pitch_y = -(CW'(r_sq[SQRT_BITS].x) <<< SCALE_SH);
        w_pre.roll  = vec_setup(w_roll_x, w_roll_y);
        w_pre.pitch = vec_setup(w_pitch_x, w_pitch_y);
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_cr[0] <= w_pre;
        end
    end

    for (genvar i = 0; i < ANGLE_STEPS; i++) begin : g_cordic
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_cr[i+1].roll  <= vec_rotate(r_cr[i].roll, i, atan_entry(i));
                r_cr[i+1].pitch <= vec_rotate(r_cr[i].pitch, i, atan_entry(i));
            end
        end
    end

    // Rounding, output register and skid entry ----------------------------

    logic signed [RND_W-1:0]   w_roll_r, w_pitch_r;
    logic                      w_leave;
    logic signed [ROLL_W-1:0]  r_out_roll, r_skid_roll;
    logic signed [PITCH_W-1:0] r_out_pitch, r_skid_pitch;
    logic                      w_out_load;

    assign w_roll_r   = round_sat(r_cr[ANGLE_STEPS].roll, ROLL_LIM);
    assign w_pitch_r  = round_sat(r_cr[ANGLE_STEPS].pitch, PITCH_LIM);
    assign w_leave    = w_en && r_valid[NSTG-1];
    assign w_out_load = !r_out_valid || o_angle.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid  <= r_skid_valid || w_leave;
            r_skid_valid <= 1'b0;
        end else if (w_leave) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            if (r_skid_valid) begin
                r_out_roll  <= r_skid_roll;
                r_out_pitch <= r_skid_pitch;
            end else begin
                r_out_roll  <= w_roll_r[ROLL_W-1:0];
                r_out_pitch <= w_pitch_r[PITCH_W-1:0];
            end
        end else if (w_leave) begin
            r_skid_roll  <= w_roll_r[ROLL_W-1:0];
            r_skid_pitch <= w_pitch_r[PITCH_W-1:0];
        end
    end

    assign o_angle.valid       = r_out_valid;
    assign o_angle.roll_angle  = r_out_roll;
    assign o_angle.pitch_angle = r_out_pitch;

    // Checks -------------------------------------------------------------

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry full while output register empty");

    a_skid_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_skid_valid ##1 r_skid_valid) |-> $past(o_angle.valid && !o_angle.ready))
        else $error("skid entry filled without a stalled output");

    a_roll_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_angle.valid |-> (o_angle.roll_angle <= 16'sd23040 &&
                           o_angle.roll_angle >= -16'sd23040))
        else $error("roll angle out of range");

    a_pitch_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_angle.valid |-> (o_angle.pitch_angle <= 15'sd11520 &&
                           o_angle.pitch_angle >= -15'sd11520))
        else $error("pitch angle out of range");

endmodule

`default_nettype wire
